@@ hdl/ugsi_pkg.sv @@
`timescale 1ns / 1ps
package ugsi_pkg;

  localparam int GRID_CELLS   = 4096;
  localparam int POOL_ENTRIES = 4096;
  localparam int RESULT_CAP   = 64;

  localparam int CELL_AW  = $clog2(GRID_CELLS);
  localparam int POOL_AW  = $clog2(POOL_ENTRIES);
  localparam int SEEN_AW  = $clog2(RESULT_CAP);
  localparam int FILL_W   = POOL_AW + 1;
  localparam int SEEN_CW  = SEEN_AW + 1;
  localparam int LIN_W    = 17;
  localparam int DEPTH_W  = 13;
  localparam int HANDLE_W = 16;
  localparam int DIV_W    = 17;
  localparam int CS_W     = 16;
  localparam int DIM_W    = 7;
  localparam int CFG_IW   = 3;
  localparam int CFG_DW   = 16;

  localparam logic [DEPTH_W-1:0] DEPTH_MAX = {DEPTH_W{1'b1}};
  localparam logic [FILL_W-1:0]  FILL_LIMIT = FILL_W'(POOL_ENTRIES - 4);

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_HIT   = 3'd0,
    ST_ADD   = 3'd1,
    ST_CLR   = 3'd2,
    ST_EMPTY = 3'd3,
    ST_FULL  = 3'd4,
    ST_OOB   = 3'd5,
    ST_LFULL = 3'd6
  } status_t;

  typedef enum logic [CFG_IW-1:0] {
    CFG_ORIGIN_X = 3'd0,
    CFG_ORIGIN_Y = 3'd1,
    CFG_CELL_SZ  = 3'd2,
    CFG_COLS     = 3'd3,
    CFG_ROWS     = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_OOB   = 2'd3
  } cmd_kind_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_DIV,
    F_WAIT,
    F_CLASS,
    F_PUSH
  } fstate_t;

  typedef enum logic [3:0] {
    B_INIT,
    B_IDLE,
    B_CLR,
    B_EMIT,
    B_ARD,
    B_AWR,
    B_QHRD,
    B_QHCK,
    B_QPRD,
    B_QPCK,
    B_QORD,
    B_QOUT
  } bstate_t;

  typedef struct packed {
    logic [1:0]          op;
    logic signed [15:0]  rect_x;
    logic signed [15:0]  rect_y;
    logic [14:0]         rect_width;
    logic [14:0]         rect_height;
    logic [HANDLE_W-1:0] item_handle;
  } in_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] found_handle;
    logic [2:0]          status;
    logic [DEPTH_W-1:0]  deepest_cell;
    logic                last;
  } out_t;

  typedef struct packed {
    cmd_kind_t                 kind;
    logic [HANDLE_W-1:0]       handle;
    logic [3:0][CELL_AW-1:0]   idx;
  } cmd_t;

  typedef struct packed {
    logic                ok;
    logic [POOL_AW-1:0]  head;
    logic [DEPTH_W-1:0]  depth;
  } cell_ent_t;

  typedef struct packed {
    logic                ok;
    logic [POOL_AW-1:0]  next;
    logic [HANDLE_W-1:0] handle;
  } pool_ent_t;

endpackage

@@ hdl/ugsi_div.sv @@
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module ugsi_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [ugsi_pkg::DIV_W-1:0]   dividend,
  input  logic [ugsi_pkg::CS_W-1:0]    divisor,
  output logic                         done,
  output logic [ugsi_pkg::DIV_W-1:0]   quotient
);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [4:0]                  cnt_r, cnt_nxt;
  logic [ugsi_pkg::CS_W-1:0]   rem_r, rem_nxt;
  logic [ugsi_pkg::CS_W-1:0]   dvs_r, dvs_nxt;
  logic [ugsi_pkg::DIV_W-1:0]  quo_r, quo_nxt;
  logic [ugsi_pkg::CS_W:0]     sh;
  logic                        ge;

  assign sh = {rem_r, quo_r[ugsi_pkg::DIV_W-1]};
  assign ge = sh >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 5'(ugsi_pkg::DIV_W);
      rem_nxt  = '0;
      quo_nxt  = dividend;
      // zero divisor acts as one
      dvs_nxt  = (divisor == '0) ? ugsi_pkg::CS_W'(1) : divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? ugsi_pkg::CS_W'(sh - {1'b0, dvs_r}) : sh[ugsi_pkg::CS_W-1:0];
      quo_nxt = {quo_r[ugsi_pkg::DIV_W-2:0], ge};
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ hdl/ugsi_front.sv @@
`timescale 1ns / 1ps
// Accepts items, maps corners to cells, classifies, hands commands on.
module ugsi_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [ugsi_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [ugsi_pkg::CFG_DW-1:0]   cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  ugsi_pkg::in_t                 in_data,
  output logic                          cmd_valid,
  input  logic                          cmd_ready,
  output ugsi_pkg::cmd_t                cmd_data
);

  ugsi_pkg::fstate_t state_r, state_nxt;
  logic signed [15:0]               ox_r, oy_r;
  logic [ugsi_pkg::CS_W-1:0]        cs_r;
  logic [ugsi_pkg::DIM_W-1:0]       cols_r, rows_r;
  ugsi_pkg::in_t                    in_r;
  logic [1:0]                       j_r;
  logic [3:0]                       neg_r;
  logic [ugsi_pkg::DIV_W-1:0]       q_r [4];
  ugsi_pkg::cmd_t                   cmd_r, cmd_nxt;

  logic [17:0] world, org, offs;
  logic        div_start, div_done;
  logic [ugsi_pkg::DIV_W-1:0] div_q;
  logic        accept;

  assign accept = in_valid && in_ready;

  always_comb begin
    unique case (j_r)
      2'd0:    world = {{2{in_r.rect_x[15]}}, in_r.rect_x};
      2'd1:    world = {{2{in_r.rect_x[15]}}, in_r.rect_x} + {3'b0, in_r.rect_width};
      2'd2:    world = {{2{in_r.rect_y[15]}}, in_r.rect_y};
      default: world = {{2{in_r.rect_y[15]}}, in_r.rect_y} + {3'b0, in_r.rect_height};
    endcase
    org  = j_r[1] ? {{2{oy_r[15]}}, oy_r} : {{2{ox_r[15]}}, ox_r};
    offs = world - org;
  end

  assign div_start = (state_r == ugsi_pkg::F_DIV) && !offs[17];

  ugsi_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (offs[ugsi_pkg::DIV_W-1:0]),
    .divisor  (cs_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // corner classification
  always_comb begin
    logic                              all_ok;
    logic [ugsi_pkg::DIV_W-1:0]        cx, cy;
    logic [2*ugsi_pkg::DIM_W-1:0]      prod;
    logic [ugsi_pkg::LIN_W-1:0]        lin;
    logic                              ok;
    all_ok = 1'b1;
    cmd_nxt = cmd_r;
    for (int c = 0; c < 4; c++) begin
      cx   = q_r[c % 2];
      cy   = q_r[2 + c / 2];
      prod = cy[ugsi_pkg::DIM_W-1:0] * cols_r;
      lin  = ugsi_pkg::LIN_W'(prod) + ugsi_pkg::LIN_W'(cx[ugsi_pkg::DIM_W-1:0]);
      ok   = !neg_r[c % 2] && !neg_r[2 + c / 2]
          && (cx < ugsi_pkg::DIV_W'(cols_r)) && (cy < ugsi_pkg::DIV_W'(rows_r))
          && (lin < ugsi_pkg::LIN_W'(ugsi_pkg::GRID_CELLS));
      all_ok = all_ok && ok;
      cmd_nxt.idx[c] = lin[ugsi_pkg::CELL_AW-1:0];
    end
    cmd_nxt.handle = in_r.item_handle;
    if (!all_ok) begin
      cmd_nxt.kind = ugsi_pkg::CMD_OOB;
    end else if (in_r.op == ugsi_pkg::OP_ADD) begin
      cmd_nxt.kind = ugsi_pkg::CMD_ADD;
    end else begin
      cmd_nxt.kind = ugsi_pkg::CMD_QUERY;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ugsi_pkg::F_IDLE: begin
        if (accept) begin
          priority if (in_data.op == ugsi_pkg::OP_CLEAR) state_nxt = ugsi_pkg::F_PUSH;
          else if (in_data.op == ugsi_pkg::OP_NONE) state_nxt = ugsi_pkg::F_IDLE;
          else state_nxt = ugsi_pkg::F_DIV;
        end
      end
      ugsi_pkg::F_DIV: begin
        if (!offs[17]) state_nxt = ugsi_pkg::F_WAIT;
        else if (j_r == 2'd3) state_nxt = ugsi_pkg::F_CLASS;
      end
      ugsi_pkg::F_WAIT: begin
        if (div_done) state_nxt = (j_r == 2'd3) ? ugsi_pkg::F_CLASS : ugsi_pkg::F_DIV;
      end
      ugsi_pkg::F_CLASS: state_nxt = ugsi_pkg::F_PUSH;
      ugsi_pkg::F_PUSH:  if (cmd_ready) state_nxt = ugsi_pkg::F_IDLE;
      default:           state_nxt = ugsi_pkg::F_IDLE;
    endcase
  end

  assign in_ready  = (state_r == ugsi_pkg::F_IDLE);
  assign cmd_valid = (state_r == ugsi_pkg::F_PUSH);
  assign cmd_data  = cmd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ugsi_pkg::F_IDLE;
      ox_r    <= '0;
      oy_r    <= '0;
      cs_r    <= ugsi_pkg::CS_W'(1);
      cols_r  <= ugsi_pkg::DIM_W'(64);
      rows_r  <= ugsi_pkg::DIM_W'(64);
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          ugsi_pkg::CFG_ORIGIN_X: ox_r   <= cfg_wdata;
          ugsi_pkg::CFG_ORIGIN_Y: oy_r   <= cfg_wdata;
          ugsi_pkg::CFG_CELL_SZ:  cs_r   <= cfg_wdata;
          ugsi_pkg::CFG_COLS:     cols_r <= cfg_wdata[ugsi_pkg::DIM_W-1:0];
          ugsi_pkg::CFG_ROWS:     rows_r <= cfg_wdata[ugsi_pkg::DIM_W-1:0];
          default: ;
        endcase
      end
    end
    if (accept) begin
      in_r  <= in_data;
      j_r   <= 2'd0;
      neg_r <= '0;
      cmd_r.kind <= ugsi_pkg::CMD_CLEAR;
    end
    if (state_r == ugsi_pkg::F_DIV && offs[17]) begin
      neg_r[j_r] <= 1'b1;
      j_r        <= j_r + 2'd1;
    end
    if (state_r == ugsi_pkg::F_WAIT && div_done) begin
      q_r[j_r] <= div_q;
      j_r      <= j_r + 2'd1;
    end
    if (state_r == ugsi_pkg::F_CLASS) cmd_r <= cmd_nxt;
  end

endmodule

@@ hdl/ugsi_cmdq.sv @@
`timescale 1ns / 1ps
// Two-entry command queue between front and back.
module ugsi_cmdq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  ugsi_pkg::cmd_t  push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output ugsi_pkg::cmd_t  pop_data
);

  ugsi_pkg::cmd_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = mem_r[rp_r];
  assign push = push_valid && push_ready;
  assign pop  = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
    if (push) mem_r[wp_r] <= push_data;
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) |-> !push) else $error("cmdq push while full");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("cmdq count out of range");
  a_pop_data: assert property (@(posedge clk) disable iff (!rst_n)
    (pop_valid && !pop && !push) |=> $stable(pop_data)) else $error("cmdq head moved");
`endif

endmodule

@@ hdl/ugsi_back.sv @@
`timescale 1ns / 1ps
// Executes commands on cell, pool and result memories.
module ugsi_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  ugsi_pkg::cmd_t  cmd_data,
  output logic            out_valid,
  input  logic            out_ready,
  output ugsi_pkg::out_t  out_data
);

  ugsi_pkg::bstate_t state_r, state_nxt;
  ugsi_pkg::cmd_t    cmd_r;
  ugsi_pkg::status_t st_r, st_nxt;
  logic [1:0]                      corner_r;
  logic [ugsi_pkg::CELL_AW-1:0]    sweep_r;
  logic [ugsi_pkg::FILL_W-1:0]     fill_r;
  logic [ugsi_pkg::DEPTH_W-1:0]    max_r;
  logic [ugsi_pkg::SEEN_CW-1:0]    cnt_r;
  logic                            ovf_r;
  logic [ugsi_pkg::POOL_AW-1:0]    ptr_r;
  logic [ugsi_pkg::SEEN_AW-1:0]    k_r;
  logic                            out_valid_r;
  ugsi_pkg::out_t                  out_r;

  ugsi_pkg::cell_ent_t cell_mem [ugsi_pkg::GRID_CELLS];
  ugsi_pkg::pool_ent_t pool_mem [ugsi_pkg::POOL_ENTRIES];
  logic [ugsi_pkg::HANDLE_W-1:0] seen_mem [ugsi_pkg::RESULT_CAP];
  logic [ugsi_pkg::HANDLE_W-1:0] cam_r [ugsi_pkg::RESULT_CAP];

  ugsi_pkg::cell_ent_t             cell_q_r, cell_wdata;
  ugsi_pkg::pool_ent_t             pool_q_r, pool_wdata;
  logic [ugsi_pkg::HANDLE_W-1:0]   seen_q_r;
  logic                            cell_we, pool_we, seen_we;
  logic [ugsi_pkg::CELL_AW-1:0]    cell_waddr, cell_raddr, cur_idx;
  logic [ugsi_pkg::DEPTH_W-1:0]    depth_new;
  logic                            slot_free, pop, dup, fin, emit;
  ugsi_pkg::out_t                  emit_data;

  assign slot_free = !out_valid_r || out_ready;
  assign cmd_ready = (state_r == ugsi_pkg::B_IDLE);
  assign pop       = cmd_valid && cmd_ready;
  assign cur_idx   = cmd_r.idx[corner_r];
  assign depth_new = (cell_q_r.depth == ugsi_pkg::DEPTH_MAX) ? cell_q_r.depth
                   : cell_q_r.depth + ugsi_pkg::DEPTH_W'(1);
  assign fin       = (ugsi_pkg::SEEN_CW'(k_r) == cnt_r - ugsi_pkg::SEEN_CW'(1));

  always_comb begin
    dup = 1'b0;
    for (int j = 0; j < ugsi_pkg::RESULT_CAP; j++) begin
      if (ugsi_pkg::SEEN_CW'(j) < cnt_r && cam_r[j] == pool_q_r.handle) dup = 1'b1;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ugsi_pkg::B_INIT, ugsi_pkg::B_CLR: begin
        if (sweep_r == {ugsi_pkg::CELL_AW{1'b1}})
          state_nxt = (state_r == ugsi_pkg::B_INIT) ? ugsi_pkg::B_IDLE : ugsi_pkg::B_EMIT;
      end
      ugsi_pkg::B_IDLE: begin
        if (pop) begin
          unique case (cmd_data.kind)
            ugsi_pkg::CMD_CLEAR: state_nxt = ugsi_pkg::B_CLR;
            ugsi_pkg::CMD_OOB:   state_nxt = ugsi_pkg::B_EMIT;
            ugsi_pkg::CMD_ADD:   state_nxt = (fill_r > ugsi_pkg::FILL_LIMIT)
                                           ? ugsi_pkg::B_EMIT : ugsi_pkg::B_ARD;
            default:             state_nxt = ugsi_pkg::B_QHRD;
          endcase
        end
      end
      ugsi_pkg::B_EMIT: if (slot_free) state_nxt = ugsi_pkg::B_IDLE;
      ugsi_pkg::B_ARD:  state_nxt = ugsi_pkg::B_AWR;
      ugsi_pkg::B_AWR:  state_nxt = (corner_r == 2'd3) ? ugsi_pkg::B_EMIT : ugsi_pkg::B_ARD;
      ugsi_pkg::B_QHRD: state_nxt = ugsi_pkg::B_QHCK;
      ugsi_pkg::B_QHCK: begin
        if (cell_q_r.ok) state_nxt = ugsi_pkg::B_QPRD;
        else state_nxt = (corner_r == 2'd3) ? ugsi_pkg::B_QORD : ugsi_pkg::B_QHRD;
      end
      ugsi_pkg::B_QPRD: state_nxt = ugsi_pkg::B_QPCK;
      ugsi_pkg::B_QPCK: begin
        if (pool_q_r.ok) state_nxt = ugsi_pkg::B_QPRD;
        else state_nxt = (corner_r == 2'd3) ? ugsi_pkg::B_QORD : ugsi_pkg::B_QHRD;
      end
      ugsi_pkg::B_QORD: state_nxt = (cnt_r == '0) ? ugsi_pkg::B_EMIT : ugsi_pkg::B_QOUT;
      ugsi_pkg::B_QOUT: begin
        if (slot_free) state_nxt = fin ? ugsi_pkg::B_IDLE : ugsi_pkg::B_QORD;
      end
      default: state_nxt = ugsi_pkg::B_IDLE;
    endcase
  end

  // memory controls and results
  always_comb begin
    cell_we    = 1'b0;
    cell_waddr = cur_idx;
    cell_wdata = '0;
    cell_raddr = cur_idx;
    pool_we    = 1'b0;
    pool_wdata = '{ok: cell_q_r.ok, next: cell_q_r.head, handle: cmd_r.handle};
    seen_we    = 1'b0;
    emit       = 1'b0;
    emit_data  = '{found_handle: '0, status: st_r, deepest_cell: max_r, last: 1'b1};
    st_nxt     = st_r;
    unique case (state_r)
      ugsi_pkg::B_INIT, ugsi_pkg::B_CLR: begin
        cell_we    = 1'b1;
        cell_waddr = sweep_r;
      end
      ugsi_pkg::B_IDLE: begin
        unique case (cmd_data.kind)
          ugsi_pkg::CMD_CLEAR: st_nxt = ugsi_pkg::ST_CLR;
          ugsi_pkg::CMD_OOB:   st_nxt = ugsi_pkg::ST_OOB;
          ugsi_pkg::CMD_ADD:   st_nxt = (fill_r > ugsi_pkg::FILL_LIMIT)
                                      ? ugsi_pkg::ST_FULL : ugsi_pkg::ST_ADD;
          default:             st_nxt = ugsi_pkg::ST_EMPTY;
        endcase
      end
      ugsi_pkg::B_EMIT: emit = slot_free;
      ugsi_pkg::B_AWR: begin
        cell_we    = 1'b1;
        cell_wdata = '{ok: 1'b1, head: fill_r[ugsi_pkg::POOL_AW-1:0], depth: depth_new};
        pool_we    = 1'b1;
      end
      ugsi_pkg::B_QPCK: begin
        seen_we = !dup && (cnt_r < ugsi_pkg::SEEN_CW'(ugsi_pkg::RESULT_CAP));
      end
      ugsi_pkg::B_QOUT: begin
        emit = slot_free;
        emit_data.found_handle = seen_q_r;
        emit_data.status = (fin && ovf_r) ? ugsi_pkg::ST_LFULL : ugsi_pkg::ST_HIT;
        emit_data.last = fin;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cell_we) cell_mem[cell_waddr] <= cell_wdata;
    cell_q_r <= cell_mem[cell_raddr];
    if (pool_we) pool_mem[fill_r[ugsi_pkg::POOL_AW-1:0]] <= pool_wdata;
    pool_q_r <= pool_mem[ptr_r];
    if (seen_we) begin
      seen_mem[cnt_r[ugsi_pkg::SEEN_AW-1:0]] <= pool_q_r.handle;
      cam_r[cnt_r[ugsi_pkg::SEEN_AW-1:0]]    <= pool_q_r.handle;
    end
    seen_q_r <= seen_mem[k_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ugsi_pkg::B_INIT;
      sweep_r     <= '0;
      fill_r      <= '0;
      max_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
      if (state_r == ugsi_pkg::B_INIT || state_r == ugsi_pkg::B_CLR) begin
        sweep_r <= sweep_r + ugsi_pkg::CELL_AW'(1);
        if (state_r == ugsi_pkg::B_CLR) fill_r <= '0;
      end
      if (pop) begin
        cmd_r    <= cmd_data;
        corner_r <= 2'd0;
        cnt_r    <= '0;
        ovf_r    <= 1'b0;
        k_r      <= '0;
      end
      if (state_r == ugsi_pkg::B_AWR) begin
        fill_r   <= fill_r + ugsi_pkg::FILL_W'(1);
        corner_r <= corner_r + 2'd1;
        if (depth_new > max_r) max_r <= depth_new;
      end
      if (state_r == ugsi_pkg::B_QHCK) begin
        if (cell_q_r.ok) ptr_r <= cell_q_r.head;
        else corner_r <= corner_r + 2'd1;
      end
      if (state_r == ugsi_pkg::B_QPCK) begin
        if (seen_we) cnt_r <= cnt_r + ugsi_pkg::SEEN_CW'(1);
        else if (!dup) ovf_r <= 1'b1;
        if (pool_q_r.ok) ptr_r <= pool_q_r.next;
        else corner_r <= corner_r + 2'd1;
      end
      if (state_r == ugsi_pkg::B_QOUT && slot_free) k_r <= k_r + ugsi_pkg::SEEN_AW'(1);
      if (emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
    if (emit) out_r <= emit_data;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= ugsi_pkg::FILL_W'(ugsi_pkg::POOL_ENTRIES)) else $error("pool overrun");
  a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= ugsi_pkg::SEEN_CW'(ugsi_pkg::RESULT_CAP)) else $error("seen list overrun");
  a_init_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ugsi_pkg::B_INIT) |-> !out_valid_r) else $error("result during init sweep");
  a_no_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (out_valid_r ? out_ready : 1'b1)) else $error("result slot overwritten");
`endif

endmodule

@@ hdl/uniform_grid_spatial_index.sv @@
`timescale 1ns / 1ps
// Channel  Direction  Handshake          Payload
// in       input      in_valid/in_ready  ugsi_pkg::in_t (op, rect, item_handle)
// out      output     out_valid/out_ready ugsi_pkg::out_t (handle, status, depth, last)
// cfg      input      cfg_we             cfg_index, cfg_wdata
//
// Add/query: front runs four serial 17-step divisions (none for a negative
// offset), then classifies and pushes. Back: an add reads and writes each
// corner; a query reads and checks each corner head and list entry walked,
// then reads and emits each result. Clear sweeps all 4096 cells, one per cycle.
// After reset the back sweeps the cell memory; items are still accepted and
// queued meanwhile. Reset is synchronous, active low.
// A two-entry command queue lets front and back stall independently.
module uniform_grid_spatial_index (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [ugsi_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [ugsi_pkg::CFG_DW-1:0]   cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  ugsi_pkg::in_t                 in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output ugsi_pkg::out_t                out_data
);

  // front -> queue
  logic           fq_valid, fq_ready;
  ugsi_pkg::cmd_t fq_data;
  // queue -> back
  logic           qb_valid, qb_ready;
  ugsi_pkg::cmd_t qb_data;

  ugsi_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (fq_valid),
    .cmd_ready (fq_ready),
    .cmd_data  (fq_data)
  );

  ugsi_cmdq u_cmdq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_data),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (qb_data)
  );

  // back owns the memories and the result register
  ugsi_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (qb_valid),
    .cmd_ready (qb_ready),
    .cmd_data  (qb_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
